// ----- rtl/wgm_pkg.sv -----
// shared types, constants and the case-fold function of the wildcard matcher
package wgm_pkg;

  localparam int STEP_LIMIT_W = 16;
  localparam int CALLS_W      = STEP_LIMIT_W + 1;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CASE_MODE  = 1'd1;

  localparam logic [STEP_LIMIT_W-1:0] STEP_LIMIT_RESET = 16'd512;

  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // input kind carried in tuser
  localparam logic KIND_MASK = 1'b0;
  localparam logic KIND_NAME = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // accepted input item
    logic init;       // clear the search pointers
    logic calls_inc;  // count one loop step
    logic m_inc;      // skip one star
    logic set_wild;   // remember the backtrack point
    logic advance;    // step both strings
    logic backtrack;  // return to the backtrack point, one name byte later
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic limit_over;
    logic star;
    logic m_end;
    logic n_end;
    logic tail_ok;
    logic wild;
    logic chars_eq;
    logic too_long;
  } status_t;

  // ascii fold, optionally also [\]^ onto {|}~
  function automatic logic [7:0] fold(input logic [7:0] c, input logic mode);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end else if (mode && (c inside {[8'h5B:8'h5E]})) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- rtl/wgm_datapath.sv -----
// string stores, configuration registers and search pointers of the matcher
module wgm_datapath #(
  parameter int MASK_DEPTH = 256,
  parameter int NAME_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                           in_kind,
  input  logic [7:0]                     in_byte,
  input  logic                           in_last,
  input  wgm_pkg::cmd_t                  cmd,
  output wgm_pkg::status_t               status
);
  import wgm_pkg::*;

  localparam int MAW = $clog2(MASK_DEPTH);
  localparam int MW  = $clog2(MASK_DEPTH + 1);
  localparam int NAW = $clog2(NAME_DEPTH);
  localparam int NLW = $clog2(NAME_DEPTH + 1);
  localparam int NW  = $clog2(NAME_DEPTH + 2);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MASK = 2'd1,
    PH_NAME = 2'd2
  } phase_t;

  phase_t                  phase;
  logic [STEP_LIMIT_W-1:0] step_limit;
  logic                    case_mode;

  logic [7:0]     mask_mem [MASK_DEPTH];
  logic [7:0]     name_mem [NAME_DEPTH];
  logic [MW-1:0]  mask_len;
  logic [NLW-1:0] name_len;
  logic           mask_ovf;
  logic           name_ovf;
  logic           tail_star;

  logic [MW-1:0]      m;
  logic [MW-1:0]      ma;
  logic [NW-1:0]      n;
  logic [NW-1:0]      na;
  logic               wild;
  logic [CALLS_W-1:0] calls;

  logic [7:0] mask_rd;
  logic [7:0] name_rd;
  logic       mask_rd_ok;
  logic       name_rd_ok;

  logic [MW-1:0]  mask_base;
  logic [NLW-1:0] name_base;
  logic           mask_wr;
  logic           name_wr;
  logic           byte_nz;
  logic [7:0]     mc;
  logic [7:0]     nc;

  // append position of the incoming byte: zero when a new string starts
  always_comb begin
    byte_nz   = (in_byte != CHAR_NUL);
    mask_base = (phase == PH_MASK) ? mask_len : '0;
    name_base = (phase == PH_NAME) ? name_len : '0;
    mask_wr   = cmd.load && (in_kind == KIND_MASK) && byte_nz &&
                (mask_base < MW'(MASK_DEPTH));
    name_wr   = cmd.load && (in_kind == KIND_NAME) && byte_nz &&
                (name_base < NLW'(NAME_DEPTH));
  end

  // configuration, lengths, flags and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      step_limit <= STEP_LIMIT_RESET;
      case_mode  <= 1'b1;
      mask_len   <= '0;
      name_len   <= '0;
      mask_ovf   <= 1'b0;
      name_ovf   <= 1'b0;
      tail_star  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_LIMIT: step_limit <= cfg_data[STEP_LIMIT_W-1:0];
          CFG_CASE_MODE:  case_mode  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (in_kind == KIND_MASK) begin
          mask_len <= mask_wr ? mask_base + 1'b1 : mask_base;
          mask_ovf <= ((phase == PH_MASK) && mask_ovf) ||
                      (byte_nz && !mask_wr);
          // last byte that is not '?' decides the end-of-mask star test
          if (mask_wr && (in_byte != CHAR_QMARK)) begin
            tail_star <= (in_byte == CHAR_STAR) && (mask_base != '0);
          end else if (phase != PH_MASK) begin
            tail_star <= 1'b0;
          end
          phase <= in_last ? PH_IDLE : PH_MASK;
        end else begin
          name_len <= name_wr ? name_base + 1'b1 : name_base;
          name_ovf <= ((phase == PH_NAME) && name_ovf) ||
                      (byte_nz && !name_wr);
          phase    <= in_last ? PH_IDLE : PH_NAME;
        end
      end
    end
  end

  // string memories, read every cycle at the search pointers
  always_ff @(posedge clk) begin
    if (mask_wr) begin
      mask_mem[mask_base[MAW-1:0]] <= in_byte;
    end
    mask_rd    <= mask_mem[m[MAW-1:0]];
    mask_rd_ok <= (m < mask_len);
  end

  always_ff @(posedge clk) begin
    if (name_wr) begin
      name_mem[name_base[NAW-1:0]] <= in_byte;
    end
    name_rd    <= name_mem[n[NAW-1:0]];
    name_rd_ok <= (n < NW'(name_len));
  end

  // search pointers and step counter
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      m     <= '0;
      ma    <= '0;
      n     <= '0;
      na    <= '0;
      wild  <= 1'b0;
      calls <= '0;
    end else begin
      if (cmd.calls_inc) begin
        calls <= calls + 1'b1;
      end
      if (cmd.m_inc) begin
        m <= m + 1'b1;
      end
      if (cmd.set_wild) begin
        wild <= 1'b1;
        ma   <= m;
        na   <= n;
      end
      if (cmd.advance) begin
        if (m < mask_len) begin
          m <= m + 1'b1;
        end
        if (n < NW'(name_len)) begin
          n <= n + 1'b1;
        end
      end
      if (cmd.backtrack) begin
        m  <= ma;
        na <= na + 1'b1;
        n  <= na + 1'b1;
      end
    end
  end

  // status back to the controller; past the end reads as nul
  always_comb begin
    mc = mask_rd_ok ? mask_rd : CHAR_NUL;
    nc = name_rd_ok ? name_rd : CHAR_NUL;
    status.limit_over = (calls > CALLS_W'(step_limit));
    status.star       = (mc == CHAR_STAR);
    status.m_end      = (m >= mask_len);
    status.n_end      = (n >= NW'(name_len));
    status.tail_ok    = tail_star;
    status.wild       = wild;
    status.chars_eq   = (fold(mc, case_mode) == fold(nc, case_mode)) ||
                        (mc == CHAR_QMARK);
    status.too_long   = mask_ovf || name_ovf;
  end

endmodule

// ----- rtl/wgm_ctrl.sv -----
// control state machine of the matcher: handshakes and the search loop
module wgm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tuser,
  input  logic             s_tlast,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic             out_matched,
  output logic             out_limit_hit,
  output logic             out_too_long,
  output wgm_pkg::cmd_t    cmd,
  input  wgm_pkg::status_t status
);
  import wgm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_CHECK,
    ST_REREAD,
    ST_BODY,
    ST_CMP_RD,
    ST_CMP,
    ST_DONE
  } state_t;

  state_t state;
  logic   seen_star;
  logic   res_matched;
  logic   res_limit_hit;
  logic   res_too_long;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // commands decoded from the state and the datapath status
  always_comb begin
    cmd = '0;
    cmd.load = accept;
    case (state)
      ST_START: cmd.init = !status.too_long;
      ST_FETCH: cmd.calls_inc = !status.limit_over;
      ST_CHECK: begin
        cmd.m_inc    = status.star;
        cmd.set_wild = !status.star && seen_star;
      end
      ST_BODY: begin
        if (status.m_end) begin
          cmd.backtrack = !status.n_end && !status.tail_ok && status.wild;
        end else if (!status.n_end) begin
          cmd.advance   = status.chars_eq;
          cmd.backtrack = !status.chars_eq && status.wild;
        end
      end
      ST_CMP: begin
        cmd.advance   = status.chars_eq;
        cmd.backtrack = !status.chars_eq && status.wild;
      end
      default: ;
    endcase
  end

  // state, result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      seen_star     <= 1'b0;
      res_matched   <= 1'b0;
      res_limit_hit <= 1'b0;
      res_too_long  <= 1'b0;
      m_tvalid      <= 1'b0;
      out_matched   <= 1'b0;
      out_limit_hit <= 1'b0;
      out_too_long  <= 1'b0;
    end else begin
      // a taken result empties the output register unless a new one enters
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (s_tuser == KIND_NAME) && s_tlast) begin
            state <= ST_START;
          end
        end
        ST_START: begin
          res_matched   <= 1'b0;
          res_limit_hit <= 1'b0;
          res_too_long  <= status.too_long;
          seen_star     <= 1'b0;
          state         <= status.too_long ? ST_DONE : ST_FETCH;
        end
        ST_FETCH: begin
          if (status.limit_over) begin
            res_limit_hit <= 1'b1;
            state         <= ST_DONE;
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (status.star) begin
            seen_star <= 1'b1;
            state     <= ST_REREAD;
          end else begin
            seen_star <= 1'b0;
            state     <= ST_BODY;
          end
        end
        ST_REREAD: state <= ST_CHECK;
        ST_BODY: begin
          if (status.m_end) begin
            if (status.n_end || status.tail_ok) begin
              res_matched <= 1'b1;
              state       <= ST_DONE;
            end else if (!status.wild) begin
              state <= ST_DONE;
            end else begin
              state <= ST_CMP_RD;
            end
          end else if (status.n_end) begin
            state <= ST_DONE;
          end else if (status.chars_eq || status.wild) begin
            state <= ST_FETCH;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_CMP_RD: state <= ST_CMP;
        ST_CMP: begin
          if (status.chars_eq || status.wild) begin
            state <= ST_FETCH;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hand the result over once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid      <= 1'b1;
            out_matched   <= res_matched;
            out_limit_hit <= res_limit_hit;
            out_too_long  <= res_too_long;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/wildcard_glob_matcher_core.sv -----
// top level of the case-insensitive wildcard matcher with a stored mask
//
// Input items arrive on the s_ channel, one string byte each: tuser 0 loads a
// mask byte, tuser 1 a name byte, tlast ends the string. The mask is kept
// across queries. A zero byte is dropped; a zero with tlast gives an empty
// string. The last name byte starts a query; mask bytes never give a result.
// One result item per query leaves on the m_ channel: matched, limit_hit
// (step_limit ran out) and too_long (a store overflowed).
// Bytes load at one per cycle while no query runs. A query runs a start state
// and a done state for setup and hand-over and, per loop step, the fetch, check
// and body states, with a reread for each star skipped and a compare read and
// compare after a backtrack at the end of the mask; at most step_limit+1 steps
// run. The read states come from the registered mask and name memory reads.
// The input is held off while a query runs. When the receiver stalls, mask
// and name bytes are still taken; a finished query waits until the pending
// result item is taken.
// Reset (rst, synchronous) empties both strings, sets step_limit to 512 and
// case_mode to 1. Configuration is written through cfg_we/cfg_index/cfg_data.
module wildcard_glob_matcher_core #(
  parameter int MASK_DEPTH = 256,
  parameter int NAME_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wgm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // char_byte
  input  logic                            s_tuser,   // command
  input  logic                            s_tlast,   // last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata    // matched, limit_hit, too_long, zeros
);
  import wgm_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    out_matched;
  logic    out_limit_hit;
  logic    out_too_long;

  wgm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tuser      (s_tuser),
    .s_tlast      (s_tlast),
    .s_tready     (s_tready),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_matched  (out_matched),
    .out_limit_hit(out_limit_hit),
    .out_too_long (out_too_long),
    .cmd          (cmd),
    .status       (status)
  );

  wgm_datapath #(
    .MASK_DEPTH(MASK_DEPTH),
    .NAME_DEPTH(NAME_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_kind  (s_tuser),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .cmd      (cmd),
    .status   (status)
  );

  // result fields packed from the lowest bit up
  assign m_tdata = {5'b00000, out_too_long, out_limit_hit, out_matched};

  // the result flags exclude each other
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(m_tdata[2:0]) <= 1))
    else $error("more than one result flag set");

  // the last name byte starts a query, which holds the input off
  a_query_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == KIND_NAME) && s_tlast) |=> !s_tready)
    else $error("input taken while a query starts");

  // an item that ends no name gives no result
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !(s_tuser && s_tlast) && !m_tvalid) |=> !m_tvalid)
    else $error("result without a query");

  // a search step never starts with the step counter past its limit
  a_step_counted: assert property (@(posedge clk) disable iff (rst)
    cmd.calls_inc |-> !status.limit_over)
    else $error("loop step counted past the limit");

endmodule
